>>> sv/fpra_pkg.sv
// Shared types and constants for the frame pacer with rate average.
// No dependencies; every other file in sv/ refers to it by scoped names.
`default_nettype none

package fpra_pkg;

  // Depth of the frame time ring; any value from 2 to 256.
  localparam int AVG_DEPTH = 16;

  localparam int WORK_W   = 24;
  localparam int BUDGET_W = 20;
  localparam int MIN_W    = 10;
  localparam int CARRY_W  = 10;
  localparam int DELAY_W  = 20;
  localparam int FRAME_W  = 24;
  localparam int AVG_W    = 24;
  localparam int FPS_W    = 16;

  localparam int SLOT_W = $clog2(AVG_DEPTH);
  localparam int SUM_W  = FRAME_W + $clog2(AVG_DEPTH);
  localparam int AREM_W = $clog2(AVG_DEPTH);
  localparam int CNT_W  = $clog2(SUM_W + 1);

  localparam int APB_DW = 32;
  localparam int ADDR_W = 4;
  localparam int REG_W  = ADDR_W - 2;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(16666);
  localparam logic [MIN_W-1:0]    MIN_RESET    = MIN_W'(350);

  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(AVG_DEPTH - 1);
  localparam logic [AREM_W:0]   DEPTH_DIV  = (AREM_W + 1)'(AVG_DEPTH);

  // fps_x256 = FPS_NUM / sum. The quotient saturates exactly when
  // sum <= FPS_NUM >> 16, so only the low 16 quotient bits are iterated.
  localparam logic [63:0]       FPS_NUM = 64'd256000000 * AVG_DEPTH;
  localparam logic [SUM_W-1:0]  FPS_HI  = SUM_W'(FPS_NUM >> FPS_W);
  localparam logic [FPS_W-1:0]  FPS_LO  = FPS_NUM[FPS_W-1:0];

  typedef enum logic [REG_W-1:0] {
    REG_BUDGET    = 2'd0,
    REG_MIN_SLEEP = 2'd1,
    REG_UNCAPPED  = 2'd2
  } fpra_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PACE,
    ST_FRAME,
    ST_DIV,
    ST_OUT
  } fpra_state_t;

  typedef struct packed {
    logic [BUDGET_W-1:0] budget;
    logic [MIN_W-1:0]    min_sleep;
    logic                uncapped;
  } fpra_cfg_t;

  typedef struct packed {
    logic load;
    logic pace_en;
    logic pace_last;
    logic frame_en;
    logic div_load;
    logic div_step;
    logic fps_step;
  } fpra_ctl_t;

endpackage

`default_nettype wire

>>> sv/fpra_if.sv
// Valid/ready channel interfaces for the frame pacer: work time in, results out.
// Depends on fpra_pkg for field widths.
`default_nettype none

interface fpra_in_if;
  logic                         valid;
  logic                         ready;
  logic [fpra_pkg::WORK_W-1:0]  work_time_us;

  modport source (output valid, output work_time_us, input ready);
  modport sink (input valid, input work_time_us, output ready);
endinterface

interface fpra_out_if;
  logic                         valid;
  logic                         ready;
  logic [fpra_pkg::DELAY_W-1:0] delay_us;
  logic                         under_rate;
  logic [fpra_pkg::AVG_W-1:0]   avg_frame_us;
  logic [fpra_pkg::FPS_W-1:0]   fps_x256;

  modport source (output valid, output delay_us, output under_rate, output avg_frame_us,
                  output fps_x256, input ready);
  modport sink (input valid, input delay_us, input under_rate, input avg_frame_us,
                input fps_x256, output ready);
endinterface

`default_nettype wire

>>> sv/fpra_regs.sv
// APB configuration registers: frame budget, minimum sleep, uncapped flag.
// Depends on fpra_pkg.
`default_nettype none

module fpra_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpra_pkg::ADDR_W-1:0]   paddr,
  input  logic [fpra_pkg::APB_DW-1:0]   pwdata,
  output logic [fpra_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output fpra_pkg::fpra_cfg_t           cfg
);

  logic                         wr;
  logic [fpra_pkg::REG_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[fpra_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.budget    <= fpra_pkg::BUDGET_RESET;
      cfg.min_sleep <= fpra_pkg::MIN_RESET;
      cfg.uncapped  <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        fpra_pkg::REG_BUDGET:    cfg.budget    <= pwdata[fpra_pkg::BUDGET_W-1:0];
        fpra_pkg::REG_MIN_SLEEP: cfg.min_sleep <= pwdata[fpra_pkg::MIN_W-1:0];
        fpra_pkg::REG_UNCAPPED:  cfg.uncapped  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      fpra_pkg::REG_BUDGET:    prdata = fpra_pkg::APB_DW'(cfg.budget);
      fpra_pkg::REG_MIN_SLEEP: prdata = fpra_pkg::APB_DW'(cfg.min_sleep);
      fpra_pkg::REG_UNCAPPED:  prdata = fpra_pkg::APB_DW'(cfg.uncapped);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/fpra_pacer.sv
// Bit-serial pacing datapath: slack, delay and carry in one pass, then frame
// time and running ring sum in a second pass. Depends on fpra_pkg.
`default_nettype none

module fpra_pacer (
  input  logic                            clk,
  input  logic                            rst,
  input  fpra_pkg::fpra_ctl_t             ctl,
  input  fpra_pkg::fpra_cfg_t             cfg,
  input  logic [fpra_pkg::WORK_W-1:0]     work_in,
  input  logic [fpra_pkg::FRAME_W-1:0]    old_frame,
  output logic [fpra_pkg::DELAY_W-1:0]    delay,
  output logic                            under,
  output logic [fpra_pkg::FRAME_W-1:0]    frame,
  output logic [fpra_pkg::SUM_W-1:0]      sum
);

  localparam int WW = fpra_pkg::WORK_W;
  localparam int BW = fpra_pkg::BUDGET_W;
  localparam int CW = fpra_pkg::CARRY_W;
  localparam int MW = fpra_pkg::MIN_W;
  localparam int DW = fpra_pkg::DELAY_W;
  localparam int FW = fpra_pkg::FRAME_W;
  localparam int SW = fpra_pkg::SUM_W;

  logic [WW-1:0] work_sr;
  logic [BW-1:0] bud_sr;
  logic [CW-1:0] carry_sr;
  logic [MW-1:0] min_sr;
  logic [WW-1:0] u_sr;
  logic [WW-1:0] s_sr;
  logic [DW-1:0] delay_sr;
  logic [FW-1:0] old_sr;
  logic [SW-1:0] frame_sr;
  logic [SW-1:0] sum_sr;
  logic [CW-1:0] carry_us;
  logic          brw1, cy2, brw3, cy4, brw5, cy6;

  logic          w, b, c, m, d, o, sb;
  logic          t_bit, s_bit, u_bit, f_bit, x_bit, y_bit;
  logic          brw1_next, cy2_next, brw3_next, cy4_next, brw5_next, cy6_next;
  logic [WW-1:0] u_full, s_full;
  logic [DW-1:0] dly_sat, dly_new;
  logic [CW-1:0] carry_new;

  assign w  = work_sr[0];
  assign b  = bud_sr[0];
  assign c  = carry_sr[0];
  assign m  = min_sr[0];
  assign d  = delay_sr[0];
  assign o  = old_sr[0];
  assign sb = sum_sr[0];

  // pass 1: t = budget - work, s = t + carry, u = s - min_sleep
  assign t_bit     = b ^ w ^ brw1;
  assign brw1_next = (~b & (w | brw1)) | (w & brw1);
  assign s_bit     = t_bit ^ c ^ cy2;
  assign cy2_next  = (t_bit & c) | (t_bit & cy2) | (c & cy2);
  assign u_bit     = s_bit ^ m ^ brw3;
  assign brw3_next = (~s_bit & (m | brw3)) | (m & brw3);
  assign u_full    = {u_bit, u_sr[WW-1:1]};
  assign s_full    = {s_bit, s_sr[WW-1:1]};

  // pass 2: f = work + delay, new sum = sum - old + f
  assign f_bit     = w ^ d ^ cy4;
  assign cy4_next  = (w & d) | (w & cy4) | (d & cy4);
  assign x_bit     = sb ^ o ^ brw5;
  assign brw5_next = (~sb & (o | brw5)) | (o & brw5);
  assign y_bit     = x_bit ^ f_bit ^ cy6;
  assign cy6_next  = (x_bit & f_bit) | (x_bit & cy6) | (f_bit & cy6);

  // slack stays below 2^21 when not under rate, so bit DW alone flags overflow
  assign dly_sat = cfg.uncapped ? '0 : (u_full[DW] ? '1 : u_full[DW-1:0]);

  always_comb begin
    if (brw1_next || brw3_next) begin
      dly_new = '0;
    end else begin
      dly_new = dly_sat;
    end
    if (!brw1_next && brw3_next) begin
      carry_new = s_full[CW-1:0];
    end else begin
      carry_new = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_us <= '0;
      sum_sr   <= '0;
    end else begin
      if (ctl.pace_last) carry_us <= carry_new;
      if (ctl.frame_en)  sum_sr   <= {y_bit, sum_sr[SW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work_sr  <= work_in;
      bud_sr   <= cfg.budget;
      carry_sr <= carry_us;
      min_sr   <= cfg.min_sleep;
      brw1     <= 1'b0;
      cy2      <= 1'b0;
      brw3     <= 1'b0;
      cy4      <= 1'b0;
      brw5     <= 1'b0;
      cy6      <= 1'b0;
    end
    if (ctl.pace_en) begin
      work_sr  <= {w, work_sr[WW-1:1]};   // rotate: work is needed again
      bud_sr   <= {1'b0, bud_sr[BW-1:1]};
      carry_sr <= {1'b0, carry_sr[CW-1:1]};
      min_sr   <= {1'b0, min_sr[MW-1:1]};
      u_sr     <= u_full;
      s_sr     <= s_full;
      brw1     <= brw1_next;
      cy2      <= cy2_next;
      brw3     <= brw3_next;
    end
    if (ctl.pace_last) begin
      under    <= brw1_next;
      delay    <= dly_new;
      delay_sr <= dly_new;
      old_sr   <= old_frame;
    end
    if (ctl.frame_en) begin
      work_sr  <= {1'b0, work_sr[WW-1:1]};
      delay_sr <= {1'b0, delay_sr[DW-1:1]};
      old_sr   <= {1'b0, old_sr[FW-1:1]};
      frame_sr <= {f_bit, frame_sr[SW-1:1]};
      cy4      <= cy4_next;
      brw5     <= brw5_next;
      cy6      <= cy6_next;
    end
  end

  // work <= budget < 2^20 whenever delay is nonzero, so frame never overflows
  assign frame = frame_sr[FW-1:0];
  assign sum   = sum_sr;

endmodule

`default_nettype wire

>>> sv/fpra_ring.sv
// Frame time ring: one write port, one registered read at the current slot,
// per-entry valid bits so unwritten entries read as zero. Depends on fpra_pkg.
`default_nettype none

module fpra_ring (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [fpra_pkg::FRAME_W-1:0]  wr_data,
  output logic [fpra_pkg::FRAME_W-1:0]  old_frame
);

  logic [fpra_pkg::FRAME_W-1:0]   mem [fpra_pkg::AVG_DEPTH];
  logic [fpra_pkg::AVG_DEPTH-1:0] vld;
  logic [fpra_pkg::SLOT_W-1:0]    slot;
  logic [fpra_pkg::FRAME_W-1:0]   rdata;
  logic                           rvld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      slot <= '0;
    end else if (wr_en) begin
      vld[slot] <= 1'b1;
      slot      <= (slot == fpra_pkg::SLOT_LAST) ? '0 : slot + fpra_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[slot] <= wr_data;
    rdata <= mem[slot];
    rvld  <= vld[slot];
  end

  assign old_frame = rvld ? rdata : '0;

endmodule

`default_nettype wire

>>> sv/fpra_div.sv
// Iterative dividers: average = sum / depth one bit per cycle on a narrow
// remainder, and fps = constant / sum one quotient bit per cycle. Depends on fpra_pkg.
`default_nettype none

module fpra_div (
  input  logic                          clk,
  input  fpra_pkg::fpra_ctl_t           ctl,
  input  logic [fpra_pkg::SUM_W-1:0]    sum,
  output logic [fpra_pkg::AVG_W-1:0]    avg,
  output logic [fpra_pkg::FPS_W-1:0]    fps
);

  localparam int SW = fpra_pkg::SUM_W;
  localparam int RW = fpra_pkg::AREM_W;
  localparam int QW = fpra_pkg::FPS_W;

  logic [SW-1:0] acc_sr;
  logic [RW-1:0] arem;
  logic [SW-1:0] divisor;
  logic [SW-1:0] frem;
  logic [QW-1:0] lo_sr;
  logic [QW-1:0] fq;
  logic          sat;

  logic [RW:0]   at;
  logic          a_ge;
  logic [SW:0]   ft;
  logic          f_ge;

  assign at   = {arem, acc_sr[SW-1]};
  assign a_ge = (at >= fpra_pkg::DEPTH_DIV);
  assign ft   = {frem, lo_sr[QW-1]};
  assign f_ge = (ft >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      acc_sr  <= sum;
      arem    <= '0;
      divisor <= sum;
      frem    <= fpra_pkg::FPS_HI;
      lo_sr   <= fpra_pkg::FPS_LO;
      sat     <= (sum <= fpra_pkg::FPS_HI);   // includes an all-zero ring
    end
    if (ctl.div_step) begin
      acc_sr <= {acc_sr[SW-2:0], 1'b0};
      arem   <= a_ge ? RW'(at - fpra_pkg::DEPTH_DIV) : at[RW-1:0];
      avg    <= {avg[fpra_pkg::AVG_W-2:0], a_ge};
    end
    if (ctl.fps_step) begin
      lo_sr <= {lo_sr[QW-2:0], 1'b0};
      frem  <= f_ge ? SW'(ft - {1'b0, divisor}) : ft[SW-1:0];
      fq    <= {fq[QW-2:0], f_ge};
    end
  end

  assign fps = sat ? '1 : fq;

endmodule

`default_nettype wire

>>> sv/frame_pacer_with_rate_average_core.sv
// Frame pacer with rate average: top level, sequencer and output register.
// Depends on fpra_pkg, fpra_if, fpra_regs, fpra_pacer, fpra_ring, fpra_div.
//
// Usage: each input beat on frame_in carries one frame's work time in
// microseconds. The block returns one beat on result per input: the delay to
// insert before the next frame, the under-rate flag, the mean frame time over
// the last AVG_DEPTH frames and the frame rate in 8.8 fixed point.
// The arithmetic runs one bit per cycle: a pass for slack and delay, a pass for
// frame time and ring sum, then the divider pass and a final output step. One item
// is in work at a time; frame_in.ready is high only while the sequencer is
// idle, so no new beat is taken until the current item reaches the output
// register. A finished result sits in the output register; the next input is
// accepted while it waits, and a stalled receiver only holds the sequencer at
// its final step until the register is free.
// Reset (rst, synchronous) restores register defaults (budget 16666 us,
// minimum sleep 350 us, capped), clears the carry, ring, sum and slot, and
// drops result.valid. The user must write configuration over APB only while
// idle; the block itself does not enforce this.
`default_nettype none

module frame_pacer_with_rate_average_core (
  input  logic                          clk,
  input  logic                          rst,
  fpra_in_if.sink                       frame_in,
  fpra_out_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpra_pkg::ADDR_W-1:0]   paddr,
  input  logic [fpra_pkg::APB_DW-1:0]   pwdata,
  output logic [fpra_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int CW = fpra_pkg::CNT_W;

  fpra_pkg::fpra_state_t        state, state_next;
  logic [CW-1:0]                cnt, cnt_next;
  fpra_pkg::fpra_ctl_t          ctl;
  fpra_pkg::fpra_cfg_t          cfg;
  logic                         out_valid;
  logic                         out_load;

  logic [fpra_pkg::DELAY_W-1:0] delay;
  logic                         under;
  logic [fpra_pkg::FRAME_W-1:0] frame;
  logic [fpra_pkg::SUM_W-1:0]   sum;
  logic [fpra_pkg::FRAME_W-1:0] old_frame;
  logic [fpra_pkg::AVG_W-1:0]   avg;
  logic [fpra_pkg::FPS_W-1:0]   fps;

  fpra_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpra_pacer u_pacer (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg),
    .work_in   (frame_in.work_time_us),
    .old_frame (old_frame),
    .delay     (delay),
    .under     (under),
    .frame     (frame),
    .sum       (sum)
  );

  // ring is written on the first divider cycle, once the frame bits are all in
  fpra_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (ctl.div_load),
    .wr_data   (frame),
    .old_frame (old_frame)
  );

  fpra_div u_div (
    .clk (clk),
    .ctl (ctl),
    .sum (sum),
    .avg (avg),
    .fps (fps)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpra_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    ctl            = '0;
    out_load       = 1'b0;
    frame_in.ready = 1'b0;
    unique case (state)
      fpra_pkg::ST_IDLE: begin
        frame_in.ready = 1'b1;
        if (frame_in.valid) begin
          ctl.load   = 1'b1;
          cnt_next   = '0;
          state_next = fpra_pkg::ST_PACE;
        end
      end
      fpra_pkg::ST_PACE: begin
        ctl.pace_en = 1'b1;
        cnt_next    = cnt + CW'(1);
        if (cnt == CW'(fpra_pkg::WORK_W - 1)) begin
          ctl.pace_last = 1'b1;
          cnt_next      = '0;
          state_next    = fpra_pkg::ST_FRAME;
        end
      end
      fpra_pkg::ST_FRAME: begin
        ctl.frame_en = 1'b1;
        cnt_next     = cnt + CW'(1);
        if (cnt == CW'(fpra_pkg::SUM_W - 1)) begin
          cnt_next   = '0;
          state_next = fpra_pkg::ST_DIV;
        end
      end
      fpra_pkg::ST_DIV: begin
        ctl.div_load = (cnt == '0);
        ctl.div_step = (cnt != '0);
        ctl.fps_step = (cnt != '0) && (cnt <= CW'(fpra_pkg::FPS_W));
        cnt_next     = cnt + CW'(1);
        if (cnt == CW'(fpra_pkg::SUM_W)) begin
          cnt_next   = '0;
          state_next = fpra_pkg::ST_OUT;
        end
      end
      fpra_pkg::ST_OUT: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = fpra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fpra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.delay_us     <= delay;
      result.under_rate   <= under;
      result.avg_frame_us <= avg;
      result.fps_x256     <= fps;
    end
  end

  assign result.valid = out_valid;

`ifndef SYNTHESIS
  // a pacing pass starts only from an accepted beat
  assert property (@(posedge clk) disable iff (rst)
    (state == fpra_pkg::ST_PACE && cnt == '0) |-> $past(frame_in.valid && frame_in.ready))
    else $error("pacing pass started without an input beat");

  // under rate never comes with an inserted delay
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.under_rate) |-> (result.delay_us == '0))
    else $error("delay inserted on an under-rate frame");

  // a mean below one microsecond means a tiny sum, so the rate must saturate
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.avg_frame_us == '0) |-> (result.fps_x256 == '1))
    else $error("fps not saturated for a near-zero ring sum");

  // the ring is written exactly once per item, right after the frame pass
  assert property (@(posedge clk) disable iff (rst)
    ctl.div_load |-> $past(state == fpra_pkg::ST_FRAME))
    else $error("ring write outside the end of a frame pass");
`endif

endmodule

`default_nettype wire
